FILE: design/dccpba_pkg.sv
// dcc packet byte assembler: shared types and constants
// used by dccpba_builder and dcc_packet_byte_assembler_unit; no dependencies
`timescale 1ns / 1ps

package dccpba_pkg;

   localparam int PKT_MAX_BYTES = 6;
   localparam int PKT_LEN_W     = $clog2(PKT_MAX_BYTES + 1);
   localparam int PKT_IDX_W     = $clog2(PKT_MAX_BYTES);

   localparam logic [7:0] IDLE_LEAD_BYTE   = 8'hFF;
   localparam logic [7:0] LONG_ADDR_PREFIX = 8'hC0;
   localparam logic [7:0] LONG_ADDR_CAP    = 8'hE7;
   localparam logic [7:0] SHORT_ADDR_RESET = 8'd127;

   typedef enum logic [2:0] {
      OP_IDLE      = 3'd0,
      OP_MULTI     = 3'd1,
      OP_OPS       = 3'd2,
      OP_BASIC_ACC = 3'd3,
      OP_EXT_ACC   = 3'd4
   } opcode_type;

   typedef logic [7:0] byte_type;

   // one packet, check byte included, len = 0 means nothing to send
   typedef struct packed {
      byte_type [PKT_MAX_BYTES-1:0] bytes;
      logic [PKT_LEN_W-1:0]         len;
   } packet_type;

endpackage

FILE: design/dcc_packet_byte_assembler_unit.sv
// dcc_packet_byte_assembler_unit: top level, request register, packet buffer, output register
// depends on dccpba_pkg and dccpba_builder
`timescale 1ns / 1ps

// One request beat becomes one model-railway DCC packet, sent out as one rsp beat per
// byte with rsp_last_byte high on the trailing xor check byte. Idle packets lead with
// 0xFF, multifunction packets with a short or a capped long address, accessory packets
// with two packed bytes; an unknown opcode gives no beats at all. A packet of n bytes
// (2 to 6, check byte included) leaves through the single output byte lane; the next
// request is registered and formed while the current packet drains, so packets follow
// each other with no gap. A request passes through the request register, the packet
// buffer and the output register. csr_short_address_max (reset 127) is always ready
// and should only be written while no packet is pending.
module dcc_packet_byte_assembler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [13:0] req_target_address,
   input  logic [7:0]  req_payload_byte0,
   input  logic [7:0]  req_payload_byte1,
   input  logic [7:0]  req_payload_byte2,
   input  logic [1:0]  req_payload_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_packet_byte,
   output logic        rsp_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_short_address_max
);
   import dccpba_pkg::*;

   // config register
   logic [7:0] short_max_ff, short_max_in;

   // request register
   logic        in_valid_ff, in_valid_in;
   logic [2:0]  opcode_ff;
   logic [13:0] address_ff;
   logic [7:0]  byte0_ff, byte1_ff, byte2_ff;
   logic [1:0]  count_ff;

   // packet buffer being drained
   logic                 buf_valid_ff, buf_valid_in;
   byte_type [PKT_MAX_BYTES-1:0] buf_bytes_ff, buf_bytes_in;
   logic [PKT_LEN_W-1:0] buf_len_ff, buf_len_in;
   logic [PKT_IDX_W-1:0] buf_idx_ff, buf_idx_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   packet_type pkt;
   logic       out_free;
   logic       emit;
   logic       emit_last;
   logic       in_take;
   logic       req_take;

   assign csr_ready = 1'b1;
   assign short_max_in = (csr_valid && csr_ready) ? csr_short_address_max : short_max_ff;

   dccpba_builder u_builder (
      .opcode            (opcode_ff),
      .target_address    (address_ff),
      .payload_byte0     (byte0_ff),
      .payload_byte1     (byte1_ff),
      .payload_byte2     (byte2_ff),
      .payload_count     (count_ff),
      .short_address_max (short_max_ff),
      .packet            (pkt)
   );

   // handshake chain: output register frees -> buffer emits -> request moves in
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = buf_valid_ff && out_free;
   assign emit_last = emit && (PKT_LEN_W'(buf_idx_ff) == buf_len_ff - PKT_LEN_W'(1));
   assign in_take   = in_valid_ff && (!buf_valid_ff || emit_last);
   assign req_ready = !in_valid_ff || in_take;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_bytes_in = buf_bytes_ff;
      buf_len_in   = buf_len_ff;
      buf_idx_in   = buf_idx_ff;
      if (in_take) begin
         // an unknown opcode forms an empty packet and is simply dropped
         buf_valid_in = (pkt.len != '0);
         buf_bytes_in = pkt.bytes;
         buf_len_in   = pkt.len;
         buf_idx_in   = '0;
      end else if (emit_last) begin
         buf_valid_in = 1'b0;
      end else if (emit) begin
         buf_idx_in = buf_idx_ff + PKT_IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = buf_bytes_ff[buf_idx_ff];
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_max_ff <= SHORT_ADDR_RESET;
         in_valid_ff  <= 1'b0;
         buf_valid_ff <= 1'b0;
         buf_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         short_max_ff <= short_max_in;
         in_valid_ff  <= in_valid_in;
         buf_valid_ff <= buf_valid_in;
         buf_idx_ff   <= buf_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff  <= req_opcode;
         address_ff <= req_target_address;
         byte0_ff   <= req_payload_byte0;
         byte1_ff   <= req_payload_byte1;
         byte2_ff   <= req_payload_byte2;
         count_ff   <= req_payload_count;
      end
      buf_bytes_ff <= buf_bytes_in;
      buf_len_ff   <= buf_len_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_byte = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;

   // a held packet always has at least a header byte and the check byte
   a_buf_len_min : assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (buf_len_ff >= PKT_LEN_W'(2)))
      else $error("packet buffer holds a packet shorter than two bytes");

   // read pointer stays inside the held packet
   a_buf_idx_range : assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (PKT_LEN_W'(buf_idx_ff) < buf_len_ff))
      else $error("packet read pointer past end of packet");

   // a non-empty packet moving in starts draining from its first byte
   a_load_start : assert property (@(posedge clock) disable iff (reset)
      (in_take && (pkt.len != '0)) |=> (buf_valid_ff && (buf_idx_ff == '0)))
      else $error("loaded packet does not start at byte zero");

   // sending the check byte with nothing behind it empties the buffer
   a_drain_done : assert property (@(posedge clock) disable iff (reset)
      (emit_last && !in_take) |=> !buf_valid_ff)
      else $error("packet buffer still full after its check byte left");

endmodule

FILE: design/dccpba_builder.sv
// dccpba_builder: combinational packet former, header + data bytes + xor check
// depends on dccpba_pkg
`timescale 1ns / 1ps

module dccpba_builder (
   input  logic [2:0]          opcode,
   input  logic [13:0]         target_address,
   input  logic [7:0]          payload_byte0,
   input  logic [7:0]          payload_byte1,
   input  logic [7:0]          payload_byte2,
   input  logic [1:0]          payload_count,
   input  logic [7:0]          short_address_max,
   output dccpba_pkg::packet_type packet
);
   import dccpba_pkg::*;

   byte_type   hdr [0:1];
   byte_type   dat [0:2];
   logic [1:0] hdr_n;
   logic [1:0] dat_n;
   logic       known;
   logic [7:0] long_hi;
   logic [PKT_LEN_W-1:0] body_n;
   byte_type   check;

   // capped long-address lead byte
   always_comb begin
      long_hi = LONG_ADDR_PREFIX | {2'b00, target_address[13:8]};
      if (long_hi > LONG_ADDR_CAP) begin
         long_hi = LONG_ADDR_CAP;
      end
   end

   always_comb begin
      hdr[0] = IDLE_LEAD_BYTE;
      hdr[1] = 8'h00;
      hdr_n  = 2'd1;
      dat[0] = payload_byte0;
      dat[1] = payload_byte1;
      dat[2] = payload_byte2;
      dat_n  = payload_count;
      known  = 1'b1;
      unique case (opcode)
         OP_IDLE: begin
            hdr[0] = IDLE_LEAD_BYTE;
         end
         OP_MULTI, OP_OPS: begin
            if (({6'd0, short_address_max} < target_address) && (opcode != OP_OPS)) begin
               hdr[0] = long_hi;
               hdr[1] = target_address[7:0];
               hdr_n  = 2'd2;
            end else begin
               hdr[0] = {1'b0, target_address[6:0]};
            end
         end
         OP_BASIC_ACC, OP_EXT_ACC: begin
            hdr[0] = {2'b10, target_address[5:0]};
            hdr[1] = {(opcode == OP_BASIC_ACC), ~target_address[8:6], payload_byte0[3:0]};
            hdr_n  = 2'd2;
            // the low nibble of byte0 rides in the second header byte
            dat[0] = payload_byte1;
            dat[1] = payload_byte2;
            dat[2] = 8'h00;
            dat_n  = (payload_count == 2'd0) ? 2'd0 : payload_count - 2'd1;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic [PKT_LEN_W-1:0] off;
      body_n = PKT_LEN_W'(hdr_n) + PKT_LEN_W'(dat_n);
      check  = 8'h00;
      packet.bytes = '0;
      for (int k = 0; k < PKT_MAX_BYTES; k++) begin
         off = PKT_LEN_W'(k) - PKT_LEN_W'(hdr_n);
         if (PKT_LEN_W'(k) < PKT_LEN_W'(hdr_n)) begin
            packet.bytes[k] = hdr[k % 2];
         end else if (PKT_LEN_W'(k) < body_n) begin
            packet.bytes[k] = dat[off[1:0]];
         end
         if (PKT_LEN_W'(k) < body_n) begin
            check = check ^ packet.bytes[k];
         end
      end
      for (int k = 0; k < PKT_MAX_BYTES; k++) begin
         if (PKT_LEN_W'(k) == body_n) begin
            packet.bytes[k] = check;
         end
      end
      packet.len = known ? body_n + PKT_LEN_W'(1) : '0;
   end

endmodule
